>>> sv/pecs_pkg.sv
// ----------------------------------------------------------------------------
// pecs_pkg
// Types, constants and helpers shared by the polygon edge clip stage.
// ----------------------------------------------------------------------------
package pecs_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 4;
  localparam int CNT_W     = $clog2(COORD_W + 1);
  localparam int CFG_W     = COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        umag_t;
  typedef logic signed [COORD_W:0]   diff_t;
  typedef logic [2*COORD_W-1:0]      prod_t;

  localparam coord_t BOUNDARY_COORD_RST = coord_t'(200 << FRAC_BITS);

  typedef enum logic [1:0] {
    SIDE_X_GE = 2'd0,
    SIDE_Y_GE = 2'd1,
    SIDE_X_LE = 2'd2,
    SIDE_Y_LE = 2'd3
  } side_t;

  typedef enum logic {
    REG_BOUNDARY_SIDE  = 1'b0,
    REG_BOUNDARY_COORD = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MUL,
    ST_DIV,
    ST_EMIT_X,
    ST_EMIT_P,
    ST_NEXT,
    ST_EMIT_END
  } state_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   final_vertex;
  } vert_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   vertex_valid;
    logic   end_of_polygon;
  } clip_item_t;

  function automatic logic point_in(side_t side, coord_t c, coord_t x, coord_t y);
    logic r;
    case (side)
      SIDE_X_GE: r = (x >= c);
      SIDE_Y_GE: r = (y >= c);
      SIDE_X_LE: r = (x <= c);
      SIDE_Y_LE: r = (y <= c);
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic diff_t diff(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic umag_t mag(diff_t v);
    diff_t t;
    t = v[COORD_W] ? -v : v;
    return t[COORD_W-1:0];
  endfunction

endpackage

>>> sv/pecs_mul.sv
// ----------------------------------------------------------------------------
// pecs_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pecs_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pecs_pkg::umag_t mult_a,
  input  pecs_pkg::umag_t mult_b,
  output logic            done,
  output pecs_pkg::prod_t product
);

  localparam int W = pecs_pkg::COORD_W;

  pecs_pkg::prod_t         prod;
  pecs_pkg::umag_t         mcand;
  logic [pecs_pkg::CNT_W-1:0] count;
  logic                    run;
  logic [W:0]              sum;

  always_comb begin
    sum = {1'b0, prod[2*W-1:W]} + (prod[0] ? {1'b0, mcand} : {(W+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && count == pecs_pkg::CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{W{1'b0}}, mult_b};
      mcand <= mult_a;
      count <= pecs_pkg::CNT_W'(W);
    end else if (run) begin
      prod  <= {sum, prod[W-1:1]};
      count <= count - pecs_pkg::CNT_W'(1);
    end
  end

  assign product = prod;

endmodule

>>> sv/pecs_div.sv
// ----------------------------------------------------------------------------
// pecs_div
// Restoring divider, one quotient bit per cycle; quotient must fit COORD_W.
// ----------------------------------------------------------------------------
module pecs_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pecs_pkg::prod_t dividend,
  input  pecs_pkg::umag_t divisor,
  output logic            done,
  output pecs_pkg::umag_t quotient
);

  localparam int W = pecs_pkg::COORD_W;

  pecs_pkg::umag_t         rem;
  pecs_pkg::umag_t         quo;
  pecs_pkg::umag_t         dsr;
  logic [pecs_pkg::CNT_W-1:0] count;
  logic                    run;
  logic [W:0]              trial;
  logic [W:0]              rdiff;
  logic                    ge;

  always_comb begin
    trial = {rem, quo[W-1]};
    rdiff = trial - {1'b0, dsr};
    ge    = ~rdiff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && count == pecs_pkg::CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[2*W-1:W];
      quo   <= dividend[W-1:0];
      dsr   <= divisor;
      count <= pecs_pkg::CNT_W'(W);
    end else if (run) begin
      rem   <= ge ? rdiff[W-1:0] : trial[W-1:0];
      quo   <= {quo[W-2:0], ge};
      count <= count - pecs_pkg::CNT_W'(1);
    end
  end

  assign quotient = quo;

endmodule

>>> sv/polygon_edge_clip_stage_unit.sv
// ----------------------------------------------------------------------------
// polygon_edge_clip_stage_unit
// One polygon clip pass against an axis-aligned boundary line.
// Vertices come in one item at a time, the last flagged by final_vertex; an
// item yields zero to four result items, and a final item that yields none
// gives one empty end marker. For each crossing edge the intersection runs
// through a bit-serial multiplier and then a restoring divider, each
// producing one bit per cycle; edges that need no intersection skip both.
// A stalled output holds the stage in its emit state until the result is
// taken. The output register lets the next item be taken while the last
// result still waits.
// ----------------------------------------------------------------------------
module polygon_edge_clip_stage_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vert_valid,
  output logic                  vert_ready,
  input  pecs_pkg::vert_item_t  vert,
  output logic                  clip_valid,
  input  logic                  clip_ready,
  output pecs_pkg::clip_item_t  clip,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [pecs_pkg::CFG_W-1:0] cfg_data
);

  pecs_pkg::state_t     state, state_next;
  pecs_pkg::side_t      side;
  pecs_pkg::coord_t     bcoord;
  pecs_pkg::coord_t     first_x, first_y, prev_x, prev_y;
  pecs_pkg::coord_t     sx, sy, ex, ey;
  pecs_pkg::coord_t     base;
  pecs_pkg::umag_t      md;
  logic                 have_first;
  logic                 fin_r, pend_close, emitted, e_in_r, neg;
  logic                 accept, s_in, e_in, close_emits, x_side, out_free, load_out;
  logic                 mul_start, mul_done, div_done;
  pecs_pkg::diff_t      da, db, dd;
  pecs_pkg::prod_t      product;
  pecs_pkg::umag_t      quotient;
  pecs_pkg::coord_t     ires;
  pecs_pkg::clip_item_t clip_next;

  assign accept   = vert_valid && vert_ready;
  assign x_side   = ~side[0];
  assign out_free = ~clip_valid || clip_ready;
  assign s_in     = pecs_pkg::point_in(side, bcoord, sx, sy);
  assign e_in     = pecs_pkg::point_in(side, bcoord, ex, ey);
  assign close_emits = pend_close &&
                       (e_in || pecs_pkg::point_in(side, bcoord, first_x, first_y));
  assign ires     = neg ? pecs_pkg::coord_t'(base - quotient)
                        : pecs_pkg::coord_t'(base + quotient);

  always_comb begin
    if (x_side) begin
      da = pecs_pkg::diff(bcoord, sx);
      db = pecs_pkg::diff(ey, sy);
      dd = pecs_pkg::diff(ex, sx);
    end else begin
      da = pecs_pkg::diff(bcoord, sy);
      db = pecs_pkg::diff(ex, sx);
      dd = pecs_pkg::diff(ey, sy);
    end
  end

  pecs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mult_a  (pecs_pkg::mag(da)),
    .mult_b  (pecs_pkg::mag(db)),
    .done    (mul_done),
    .product (product)
  );

  pecs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (product),
    .divisor  (md),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pecs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    vert_ready = 1'b0;
    load_out   = 1'b0;
    mul_start  = 1'b0;
    clip_next  = '0;
    case (state)
      pecs_pkg::ST_IDLE: begin
        vert_ready = 1'b1;
        if (vert_valid && (have_first || vert.final_vertex)) begin
          state_next = pecs_pkg::ST_CLASSIFY;
        end
      end
      pecs_pkg::ST_CLASSIFY: begin
        if (s_in != e_in) begin
          mul_start  = 1'b1;
          state_next = pecs_pkg::ST_MUL;
        end else if (e_in) begin
          state_next = pecs_pkg::ST_EMIT_P;
        end else begin
          state_next = pecs_pkg::ST_NEXT;
        end
      end
      pecs_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = pecs_pkg::ST_DIV;
        end
      end
      pecs_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = pecs_pkg::ST_EMIT_X;
        end
      end
      pecs_pkg::ST_EMIT_X: begin
        clip_next.out_x          = x_side ? bcoord : ires;
        clip_next.out_y          = x_side ? ires : bcoord;
        clip_next.vertex_valid   = 1'b1;
        clip_next.end_of_polygon = fin_r && !e_in_r && !close_emits;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = e_in_r ? pecs_pkg::ST_EMIT_P : pecs_pkg::ST_NEXT;
        end
      end
      pecs_pkg::ST_EMIT_P: begin
        clip_next.out_x          = ex;
        clip_next.out_y          = ey;
        clip_next.vertex_valid   = 1'b1;
        clip_next.end_of_polygon = fin_r && !close_emits;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = pecs_pkg::ST_NEXT;
        end
      end
      pecs_pkg::ST_NEXT: begin
        if (pend_close) begin
          state_next = pecs_pkg::ST_CLASSIFY;
        end else if (fin_r && !emitted) begin
          state_next = pecs_pkg::ST_EMIT_END;
        end else begin
          state_next = pecs_pkg::ST_IDLE;
        end
      end
      pecs_pkg::ST_EMIT_END: begin
        clip_next.end_of_polygon = 1'b1;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = pecs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pecs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side       <= pecs_pkg::SIDE_X_GE;
      bcoord     <= pecs_pkg::BOUNDARY_COORD_RST;
      have_first <= 1'b0;
      clip_valid <= 1'b0;
      pend_close <= 1'b0;
      emitted    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pecs_pkg::REG_BOUNDARY_SIDE:  side   <= pecs_pkg::side_t'(cfg_data[1:0]);
          pecs_pkg::REG_BOUNDARY_COORD: bcoord <= pecs_pkg::coord_t'(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        have_first <= ~vert.final_vertex;
        pend_close <= have_first && vert.final_vertex;
        emitted    <= 1'b0;
      end else if (state == pecs_pkg::ST_NEXT) begin
        pend_close <= 1'b0;
      end
      if (load_out) begin
        emitted    <= 1'b1;
        clip_valid <= 1'b1;
      end else if (clip_ready) begin
        clip_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin_r  <= vert.final_vertex;
      prev_x <= vert.vertex_x;
      prev_y <= vert.vertex_y;
      ex     <= vert.vertex_x;
      ey     <= vert.vertex_y;
      if (have_first) begin
        sx <= prev_x;
        sy <= prev_y;
      end else begin
        sx      <= vert.vertex_x;
        sy      <= vert.vertex_y;
        first_x <= vert.vertex_x;
        first_y <= vert.vertex_y;
      end
    end
    if (state == pecs_pkg::ST_CLASSIFY) begin
      e_in_r <= e_in;
      md     <= pecs_pkg::mag(dd);
      neg    <= da[pecs_pkg::COORD_W] ^ db[pecs_pkg::COORD_W] ^ dd[pecs_pkg::COORD_W];
      base   <= x_side ? sy : sx;
    end
    if (state == pecs_pkg::ST_NEXT && pend_close) begin
      sx <= ex;
      sy <= ey;
      ex <= first_x;
      ey <= first_y;
    end
    if (load_out) begin
      clip <= clip_next;
    end
  end

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    mul_done |=> state == pecs_pkg::ST_DIV)
    else $error("divider not started after multiply");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == pecs_pkg::ST_DIV)
    else $error("divide finished outside divide state");

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    clip_valid && !clip.vertex_valid |->
      clip.end_of_polygon && clip.out_x == '0 && clip.out_y == '0)
    else $error("malformed end marker");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !clip_valid || clip_ready)
    else $error("output register overwritten");

endmodule

>>> tb/polygon_edge_clip_stage_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_edge_clip_stage_unit_test
// Drives vertex items into the clip stage and checks every clipped item
// against a predictor of the stage. The run opens with a directed set of
// polygons: single vertices, fully inside, fully outside, crossing, an edge
// on the boundary and coordinate extremes. It then runs random polygons under
// several boundary settings, the extremes among them, with bursty input and a
// receiver that stalls in changing patterns.
// ----------------------------------------------------------------------------

class clip_scoreboard;
  pecs_pkg::side_t      side;
  longint               bound;
  longint               first_x, first_y, prev_x, prev_y;
  bit                   open;
  pecs_pkg::clip_item_t clipped_q[$];
  pecs_pkg::clip_item_t fresh_q[$];
  int                   errors;

  function new();
    side    = pecs_pkg::SIDE_X_GE;
    bound   = longint'(pecs_pkg::BOUNDARY_COORD_RST);
    first_x = 0;
    first_y = 0;
    prev_x  = 0;
    prev_y  = 0;
    open    = 1'b0;
    errors  = 0;
  endfunction

  function void add_point(longint x, longint y);
    pecs_pkg::clip_item_t r;
    r.out_x          = pecs_pkg::coord_t'(x);
    r.out_y          = pecs_pkg::coord_t'(y);
    r.vertex_valid   = 1'b1;
    r.end_of_polygon = 1'b0;
    fresh_q = {fresh_q, r};
  endfunction

  function bit keeps(longint x, longint y);
    case (side)
      pecs_pkg::SIDE_X_GE: return x >= bound;
      pecs_pkg::SIDE_Y_GE: return y >= bound;
      pecs_pkg::SIDE_X_LE: return x <= bound;
      default:             return y <= bound;
    endcase
  endfunction

  // start + a*b/d, quotient truncated toward zero
  function longint lerp(longint start, longint a, longint b, longint d);
    if (d == 0) return start;
    return start + (a * b) / d;
  endfunction

  function void add_crossing(longint sx, longint sy, longint px, longint py);
    if (side == pecs_pkg::SIDE_X_GE || side == pecs_pkg::SIDE_X_LE)
      add_point(bound, lerp(sy, bound - sx, py - sy, px - sx));
    else
      add_point(lerp(sx, bound - sy, px - sx, py - sy), bound);
  endfunction

  function void clip_edge(longint sx, longint sy, longint px, longint py);
    bit s_in, p_in;
    s_in = keeps(sx, sy);
    p_in = keeps(px, py);
    if (p_in) begin
      if (!s_in) add_crossing(sx, sy, px, py);
      add_point(px, py);
    end else if (s_in) begin
      add_crossing(sx, sy, px, py);
    end
  endfunction

  function void note_vertex(pecs_pkg::vert_item_t v);
    longint px, py;
    pecs_pkg::clip_item_t marker;
    px = longint'($signed(v.vertex_x));
    py = longint'($signed(v.vertex_y));
    fresh_q.delete();
    if (!open) begin
      first_x = px;
      first_y = py;
      open    = 1'b1;
    end else begin
      clip_edge(prev_x, prev_y, px, py);
    end
    prev_x = px;
    prev_y = py;
    if (v.final_vertex) begin
      clip_edge(prev_x, prev_y, first_x, first_y);
      open = 1'b0;
      if (fresh_q.size() == 0) begin
        marker = '0;
        marker.end_of_polygon = 1'b1;
        fresh_q = {fresh_q, marker};
      end else begin
        fresh_q[fresh_q.size()-1].end_of_polygon = 1'b1;
      end
    end
    clipped_q = {clipped_q, fresh_q};
  endfunction

  function void check_result(pecs_pkg::clip_item_t got);
    pecs_pkg::clip_item_t want;
    if (clipped_q.size() == 0) begin
      $error("clipped item with none expected: x %0d y %0d valid %0b end %0b",
             $signed(got.out_x), $signed(got.out_y), got.vertex_valid, got.end_of_polygon);
      errors++;
      return;
    end
    want = clipped_q.pop_front();
    if (got.out_x !== want.out_x) begin
      $error("out_x expected %0d got %0d", $signed(want.out_x), $signed(got.out_x));
      errors++;
    end
    if (got.out_y !== want.out_y) begin
      $error("out_y expected %0d got %0d", $signed(want.out_y), $signed(got.out_y));
      errors++;
    end
    if (got.vertex_valid !== want.vertex_valid) begin
      $error("vertex_valid expected %0b got %0b", want.vertex_valid, got.vertex_valid);
      errors++;
    end
    if (got.end_of_polygon !== want.end_of_polygon) begin
      $error("end_of_polygon expected %0b got %0b", want.end_of_polygon, got.end_of_polygon);
      errors++;
    end
  endfunction

  function int pending();
    return clipped_q.size();
  endfunction
endclass

module polygon_edge_clip_stage_unit_test;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 42;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIR_N        = 19;

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      vert_valid = 1'b0;
  logic                      vert_ready;
  pecs_pkg::vert_item_t      vert       = '0;
  logic                      clip_valid;
  logic                      clip_ready = 1'b0;
  pecs_pkg::clip_item_t      clip;
  logic                      cfg_we     = 1'b0;
  logic                      cfg_index  = pecs_pkg::REG_BOUNDARY_SIDE;
  logic [pecs_pkg::CFG_W-1:0] cfg_data  = '0;

  clip_scoreboard sb = new();
  int burst_left = 0;
  int cycles     = 0;

  int dir_x[DIR_N] = '{4000, 0, 4000, 5000, 32767, -32768, 0, 3199, 0, 6400, 6400, 0,
                       3200, 3200, 1000, -32768, 32767, 32767, -32768};
  int dir_y[DIR_N] = '{0, 0, 100, -32768, 32767, -32768, 32767, 0, 0, 0, 6400, 6400,
                       -100, 100, 100, -32768, 32767, -32768, 32767};
  bit dir_f[DIR_N] = '{1, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1};

  polygon_edge_clip_stage_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .vert_valid (vert_valid),
    .vert_ready (vert_ready),
    .vert       (vert),
    .clip_valid (clip_valid),
    .clip_ready (clip_ready),
    .clip       (clip),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && clip_valid && clip_ready) sb.check_result(clip);
  end

  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 200);
      end
      left--;
      case (mode)
        0: clip_ready <= 1'b1;
        1: clip_ready <= 1'($urandom_range(0, 1));
        2: clip_ready <= ($urandom_range(0, 3) == 0);
        default: clip_ready <= ((left % 24) > 18);
      endcase
    end
  end

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    return $urandom_range(1, 10);
  endfunction

  function automatic pecs_pkg::vert_item_t make_vertex(longint x, longint y, bit fin);
    pecs_pkg::vert_item_t v;
    v.vertex_x     = pecs_pkg::coord_t'(x);
    v.vertex_y     = pecs_pkg::coord_t'(y);
    v.final_vertex = fin;
    return v;
  endfunction

  function automatic longint pick_coord(longint c);
    longint t;
    case ($urandom_range(0, 9))
      0: return longint'($signed(pecs_pkg::coord_t'($urandom)));
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return c;
      default: begin
        t = c + longint'($urandom_range(0, 4000)) - 2000;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t;
      end
    endcase
  endfunction

  task automatic push_vertex(pecs_pkg::vert_item_t v, int gap);
    @(negedge clk);
    vert_valid <= 1'b1;
    vert       <= v;
    @(posedge clk);
    while (!vert_ready) @(posedge clk);
    sb.note_vertex(v);
    if (gap > 0) begin
      @(negedge clk);
      vert_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    vert_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pecs_pkg::cfg_reg_t idx, logic [pecs_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == pecs_pkg::REG_BOUNDARY_SIDE) sb.side = pecs_pkg::side_t'(val[1:0]);
    else sb.bound = longint'($signed(val));
  endtask

  initial begin
    int sent, len;
    longint c;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      push_vertex(make_vertex(dir_x[i], dir_y[i], dir_f[i]), next_gap());
    release_input();

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: c = 32767;
        1: c = -32768;
        2: c = 0;
        3: c = longint'(pecs_pkg::BOUNDARY_COORD_RST);
        default: c = $urandom_range(0, 2) == 0
                     ? longint'($signed(pecs_pkg::coord_t'($urandom)))
                     : longint'($urandom_range(0, 8000)) - 4000;
      endcase
      write_reg(pecs_pkg::REG_BOUNDARY_SIDE, pecs_pkg::CFG_W'(p % 4));
      write_reg(pecs_pkg::REG_BOUNDARY_COORD, pecs_pkg::coord_t'(c));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_vertex(make_vertex(pick_coord(c), pick_coord(c), k == len - 1), next_gap());
        sent += len;
      end
      release_input();
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
